// ===== hw/rtl/fccw_pkg.sv =====
// Shared constants, codes and control/status types of the FAT12 cluster chain walker.
package fccw_pkg;

    // FAT store size in bytes, and the address width that follows from it
    localparam int FAT_BYTES = 8192;
    localparam int FAT_AW    = $clog2(FAT_BYTES);
    localparam logic [31:0] FAT_BYTES_U = 32'(FAT_BYTES);

    localparam int CLU_W  = 12;   // cluster number
    localparam int AT_W   = 13;   // byte offset of an entry: cluster*3/2 always fits
    localparam int SEC_W  = 25;   // first data sector
    localparam int OFF_W  = 13;   // table_offset field
    localparam int BYTE_W = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int S_TUSER_W = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CLU_W-1:0] END_MARK   = 12'hFF8;
    localparam logic [CLU_W-1:0] ENTRY_MASK = 12'hFFF;

    // Item kinds (tuser)
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_START   = 2'd1;
    localparam logic [1:0] MODE_ADVANCE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAT_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAT_COPY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECT_LOG2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLU_SECT  = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic store;      // write the input byte into the FAT store
        logic res_plain;  // form a result without walking (load, void advance, unused kind)
        logic take_start; // current cluster <= start cluster
        logic rd_lo;      // read the low entry byte
        logic rd_hi;      // read the high entry byte, hold the low one
        logic decode;     // current cluster <= decoded entry
        logic judge;      // classify cluster, form the products
        logic sum;        // add up the first sector, form the result
        logic out_load;   // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic active;     // a chain is being walked
        logic out_free;   // output register can take a word this cycle
    } t_dp_sts;

endpackage

// ===== hw/rtl/fccw_ctrl.sv =====
// Sequencing state machine of the FAT12 cluster chain walker.
module fccw_ctrl
    import fccw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TUSER_W-1:0] i_mode,
    input  t_dp_sts              i_sts,
    output t_dp_cmd              o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_HI,
        ST_DECODE,
        ST_JUDGE,
        ST_SUM,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   w_acc;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (i_mode)
                        MODE_LOAD: begin
                            o_cmd.store     = 1'b1;
                            o_cmd.res_plain = 1'b1;
                            n_state         = ST_DONE;
                        end
                        MODE_START: begin
                            o_cmd.take_start = 1'b1;
                            n_state          = ST_JUDGE;
                        end
                        MODE_ADVANCE: begin
                            if (i_sts.active) begin
                                o_cmd.rd_lo = 1'b1;
                                n_state     = ST_RD_HI;
                            end else begin
                                o_cmd.res_plain = 1'b1;
                                n_state         = ST_DONE;
                            end
                        end
                        default: begin
                            o_cmd.res_plain = 1'b1;
                            n_state         = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = ST_DECODE;
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = ST_JUDGE;
            end
            ST_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state     = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // a store read is only issued for a cluster that passed its check
    a_rd_needs_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_lo |-> i_sts.active)
        else $error("entry read issued without an active chain");

    // the two entry bytes are read in consecutive cycles
    a_rd_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_lo |=> o_cmd.rd_hi)
        else $error("high entry byte not read after low byte");
`endif

endmodule

// ===== hw/rtl/fccw_datapath.sv =====
// FAT store, chain state, sector arithmetic and output register of the cluster chain walker.
module fccw_datapath
    import fccw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [OFF_W-1:0]      i_offset,
    input  logic [BYTE_W-1:0]     i_byte,
    input  logic [CLU_W-1:0]      i_start,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [CLU_W-1:0]      o_cluster,
    output logic [SEC_W-1:0]      o_sector,
    output logic [1:0]            o_status
);

    // configuration
    logic [15:0] r_reserved, r_fat_size, r_root_ent;
    logic [7:0]  r_fat_copy, r_clu_sect;
    logic [3:0]  r_sect_log2;

    // FAT store
    logic [BYTE_W-1:0] r_fat [FAT_BYTES];
    logic [BYTE_W-1:0] r_rd;
    logic [BYTE_W-1:0] r_lo;
    logic              w_mem_re;
    logic [FAT_AW-1:0] w_raddr;
    logic              w_hit;

    // chain state
    logic [CLU_W-1:0] r_cur;
    logic             r_active;
    logic [AT_W-1:0]  w_at;
    logic [15:0]      w_word;
    logic [CLU_W-1:0] w_next;

    // arithmetic
    logic [1:0]       w_judge;
    logic [1:0]       r_jstat;
    logic [23:0]      r_mul_fat;
    logic [19:0]      r_mul_clu;
    logic [21:0]      r_root_secs;
    logic [21:0]      w_root_bytes;
    logic [21:0]      w_round;
    logic [25:0]      w_sum;

    // pending result and output register
    logic [CLU_W-1:0] r_res_cluster;
    logic [SEC_W-1:0] r_res_sector;
    logic [1:0]       r_res_status;
    logic             r_out_valid;
    logic [CLU_W-1:0] r_out_cluster;
    logic [SEC_W-1:0] r_out_sector;
    logic [1:0]       r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved  <= 16'd1;
            r_fat_size  <= 16'd9;
            r_fat_copy  <= 8'd2;
            r_root_ent  <= 16'd224;
            r_sect_log2 <= 4'd9;
            r_clu_sect  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RESERVED:  r_reserved  <= i_cfg_data;
                REG_FAT_SIZE:  r_fat_size  <= i_cfg_data;
                REG_FAT_COPY:  r_fat_copy  <= i_cfg_data[7:0];
                REG_ROOT_ENT:  r_root_ent  <= i_cfg_data;
                REG_SECT_LOG2: r_sect_log2 <= i_cfg_data[3:0];
                REG_CLU_SECT:  r_clu_sect  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // entry offset cluster*3/2
    assign w_at     = {1'b0, r_cur} + {2'b00, r_cur[CLU_W-1:1]};
    assign w_hit    = (32'(i_offset) < FAT_BYTES_U);
    assign w_mem_re = i_cmd.rd_lo || i_cmd.rd_hi;
    assign w_raddr  = i_cmd.rd_hi ? FAT_AW'(w_at + AT_W'(1)) : FAT_AW'(w_at);

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && w_hit) begin
            r_fat[FAT_AW'(i_offset)] <= i_byte;
        end
        if (w_mem_re) begin
            r_rd <= r_fat[w_raddr];
        end
    end

    // odd clusters take the upper twelve bits of the little-endian pair
    assign w_word = {r_rd, r_lo};
    assign w_next = r_cur[0] ? (CLU_W'(w_word >> 4) & ENTRY_MASK)
                             : (w_word[CLU_W-1:0] & ENTRY_MASK);

    always_comb begin
        if (r_cur >= END_MARK) begin
            w_judge = ST_END;
        end else if (r_cur < CLU_W'(2)) begin
            w_judge = ST_BAD;
        end else if (32'(w_at) + 32'd1 >= FAT_BYTES_U) begin
            w_judge = ST_BAD;
        end else begin
            w_judge = ST_OK;
        end
    end

    // ceil(32*root_entries / sector size)
    assign w_root_bytes = {1'b0, r_root_ent, 5'b00000};
    assign w_round      = ~(22'h3FFFFF << r_sect_log2);
    assign w_sum = 26'(r_reserved) + 26'(r_mul_fat) + 26'(r_root_secs) + 26'(r_mul_clu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_active <= 1'b0;
        end else begin
            if (i_cmd.take_start) begin
                r_cur    <= i_start;
                r_active <= 1'b0;
            end else if (i_cmd.decode) begin
                r_cur    <= w_next;
                r_active <= 1'b0;
            end else if (i_cmd.judge) begin
                r_active <= (w_judge == ST_OK);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_hi) begin
            r_lo <= r_rd;
        end
        if (i_cmd.judge) begin
            r_jstat     <= w_judge;
            r_mul_fat   <= 24'(r_fat_copy) * 24'(r_fat_size);
            r_mul_clu   <= (20'(r_cur) - 20'd2) * 20'(r_clu_sect);
            r_root_secs <= (w_root_bytes + w_round) >> r_sect_log2;
        end
        if (i_cmd.sum) begin
            r_res_cluster <= r_cur;
            r_res_status  <= r_jstat;
            r_res_sector  <= (r_jstat == ST_OK) ? w_sum[SEC_W-1:0] : '0;
        end else if (i_cmd.res_plain) begin
            r_res_cluster <= r_cur;
            r_res_status  <= (i_cmd.store && w_hit) ? ST_OK : ST_BAD;
            r_res_sector  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cluster <= r_res_cluster;
            r_out_sector  <= r_res_sector;
            r_out_status  <= r_res_status;
        end
    end

    assign o_sts.active   = r_active;
    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_cluster      = r_out_cluster;
    assign o_sector       = r_out_sector;
    assign o_status       = r_out_status;

`ifndef SYNTHESIS
    // an active chain always sits on a usable cluster
    a_active_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_cur >= CLU_W'(2) && r_cur < END_MARK))
        else $error("active chain on unusable cluster");

    // only an ok result carries a sector number
    a_sector_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_sector == '0))
        else $error("sector given with non-ok status");

    // never overwrite a word that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("output word overwritten");
`endif

endmodule

// ===== hw/rtl/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker: stream ports, controller and datapath.
//
// Walks a FAT12 allocation chain held in an on-chip 8 KiB byte store. Every input word
// gives exactly one output word. The kind of a word is carried in tuser: load a FAT byte,
// start a chain at a cluster, or advance to the next cluster. Load words write the store;
// reading a store byte that was never loaded gives an arbitrary entry, so load the whole
// table before walking it. There is no clearing pass after reset: the store is usable
// at once. Each output word carries the now-current cluster, its first data sector
// (reserved + copies*fat size + root directory sectors + (cluster-2)*cluster size) and a
// status: ok, end of chain (0xFF8 and above), or bad (cluster below 2, entry past the
// store, load offset past the store, advance with no live chain, or the unused kind).
// Items are handled one at a time. A load, or any word answered without walking, goes straight
// to the result; a start first checks the cluster and forms the two products, then adds up
// the sector; an advance first reads the two entry bytes one after the other from the single
// read port of the store and decodes them, before the decoded cluster goes through the same
// check and sum. The output register frees the input side: the next word is taken while a
// result still waits, and a stalled output only holds the block once the following result
// is ready. The configuration registers must be written only while the block is idle;
// the block itself does not enforce this.
module fat12_cluster_chain_walker
    import fccw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // table_offset[12:0], table_byte[20:13],
                                              // start_cluster[32:21], zero pad
    input  logic [S_TUSER_W-1:0]  i_s_tuser,  // mode[1:0]
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,  // cluster[11:0], first_sector[36:12],
                                              // status[38:37], zero pad
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    logic [CLU_W-1:0] w_cluster;
    logic [SEC_W-1:0] w_sector;
    logic [1:0]       w_status;

    // sequence one word at a time
    fccw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_mode     (i_s_tuser),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // store, chain state, arithmetic and output register
    fccw_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_offset   (i_s_tdata[12:0]),
        .i_byte     (i_s_tdata[20:13]),
        .i_start    (i_s_tdata[32:21]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cluster  (w_cluster),
        .o_sector   (w_sector),
        .o_status   (w_status)
    );

    // pack the result word, lowest field first
    assign o_m_tdata = {1'b0, w_status, w_sector, w_cluster};

endmodule
